>>> hdl/fht_pkg.sv
// Shared types, codes and sizing constants of the handle table block.
package fht_pkg;

  localparam int MAX_HANDLES = 16;
  localparam int MAX_FILES   = 4;
  localparam int NUM_SIZES   = 4;

  localparam int CMD_W     = 2;
  localparam int FILE_W    = 2;
  localparam int MODE_W    = 2;
  localparam int HANDLE_W  = 4;
  localparam int COUNT_W   = 16;
  localparam int SIZE_W    = 16;
  localparam int STATUS_W  = 3;
  localparam int PRESENT_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Table indexing and free-list counters follow the table depth.
  localparam int HIDX_W = $clog2(MAX_HANDLES);
  localparam int FILL_W = $clog2(MAX_HANDLES + 1);

  localparam int QUEUE_DEPTH = 2;

  localparam logic [MODE_W-1:0] MODE_READ = 2'b01;

  typedef enum logic [CMD_W-1:0] {
    CMD_OPEN  = 2'd0,
    CMD_CLOSE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_NO_MODE      = 3'd1,
    ST_NO_FILE      = 3'd2,
    ST_BAD_HANDLE   = 3'd3,
    ST_NOT_READABLE = 3'd4,
    ST_NO_FREE      = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILES_PRESENT = 3'd0,
    CFG_SIZE_0        = 3'd1,
    CFG_SIZE_1        = 3'd2,
    CFG_SIZE_2        = 3'd3,
    CFG_SIZE_3        = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_OPEN,
    OP_CLOSE,
    OP_READ,
    OP_REJECT
  } op_kind_t;

  // One classified command as it travels from the front end to the engine.
  typedef struct packed {
    op_kind_t              kind;
    status_t               reject;
    logic [FILE_W-1:0]     file_index;
    logic [MODE_W-1:0]     mode;
    logic [HANDLE_W-1:0]   handle;
    logic [COUNT_W-1:0]    count;
  } op_t;

  typedef logic [NUM_SIZES-1:0][SIZE_W-1:0] size_vec_t;

endpackage

>>> hdl/fht_req_if.sv
// Command channel of the handle table block.
interface fht_req_if import fht_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [FILE_W-1:0]   file_index;
  logic [MODE_W-1:0]   open_mode;
  logic [HANDLE_W-1:0] handle_in;
  logic [COUNT_W-1:0]  byte_count;

  modport source (output valid, cmd, file_index, open_mode, handle_in, byte_count,
                  input ready);
  modport sink (input valid, cmd, file_index, open_mode, handle_in, byte_count,
                output ready);
endinterface

>>> hdl/fht_rsp_if.sv
// Result channel of the handle table block.
interface fht_rsp_if import fht_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] handle_out;
  logic [COUNT_W-1:0]  bytes_granted;
  logic [SIZE_W-1:0]   data_offset;
  logic [FILE_W-1:0]   file_out;

  modport source (output valid, status, handle_out, bytes_granted, data_offset, file_out,
                  input ready);
  modport sink (input valid, status, handle_out, bytes_granted, data_offset, file_out,
                output ready);
endinterface

>>> hdl/fht_cfg_if.sv
// Register write channel of the handle table block.
interface fht_cfg_if import fht_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/fht_front.sv
// Front end: takes command beats and classifies them into table operations.
module fht_front import fht_pkg::*; (
  fht_req_if.sink         req,
  input  logic [PRESENT_W-1:0] files_present,
  input  logic            q_ready,
  output logic            q_push,
  output op_t             q_op
);

  logic [PRESENT_W-1:0] present;

  always_comb begin
    // Counts above the store size are treated as the store size.
    present = (files_present > PRESENT_W'(MAX_FILES)) ? PRESENT_W'(MAX_FILES)
                                                      : files_present;
    req.ready = q_ready;
    q_push    = req.valid && q_ready;

    q_op.kind       = OP_REJECT;
    q_op.reject     = ST_BAD_HANDLE;
    q_op.file_index = req.file_index;
    q_op.mode       = req.open_mode;
    q_op.handle     = req.handle_in;
    q_op.count      = req.byte_count;

    case (req.cmd)
      CMD_OPEN: begin
        if (req.open_mode == '0) begin
          q_op.reject = ST_NO_MODE;
        end else if (PRESENT_W'(req.file_index) >= present) begin
          q_op.reject = ST_NO_FILE;
        end else begin
          q_op.kind = OP_OPEN;
        end
      end
      CMD_CLOSE: q_op.kind = OP_CLOSE;
      CMD_READ:  q_op.kind = OP_READ;
      default:   q_op.kind = OP_REJECT;
    endcase
  end

endmodule

>>> hdl/fht_queue.sv
// Short operation queue between the front end and the table engine.
module fht_queue import fht_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic push_ready,
  input  logic pop,
  output logic pop_valid,
  output op_t  pop_op
);

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_op     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hdl/fht_engine.sv
// Table engine: owns the handle table and free list and produces result beats.
module fht_engine import fht_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  op_t       q_op,
  output logic      q_pop,
  input  size_vec_t file_size,
  fht_rsp_if.source rsp
);

  logic [MAX_HANDLES-1:0] entry_valid;
  logic [MODE_W-1:0]      entry_mode   [MAX_HANDLES];
  logic [FILE_W-1:0]      entry_file   [MAX_HANDLES];
  logic [SIZE_W-1:0]      entry_cursor [MAX_HANDLES];
  logic [HIDX_W-1:0]      free_fifo    [MAX_HANDLES];
  logic [HIDX_W-1:0]      fifo_head;
  logic [HIDX_W-1:0]      fifo_tail;
  logic [FILL_W-1:0]      fifo_fill;
  logic [FILL_W-1:0]      next_unused;

  logic [HIDX_W-1:0] hidx;
  logic              h_ok;
  logic              have_fifo;
  logic              have_new;
  logic [HIDX_W-1:0] nh;
  logic              open_ok;
  logic              close_ok;
  logic              read_ok;
  logic              push_free;
  logic [SIZE_W-1:0] cur;
  logic [FILE_W-1:0] efile;
  logic [SIZE_W-1:0] size;
  logic              at_end;
  logic [SIZE_W-1:0] avail;
  logic [SIZE_W-1:0] grant;
  status_t           res_status;

  always_comb begin
    q_pop     = q_valid && (!rsp.valid || rsp.ready);
    hidx      = q_op.handle[HIDX_W-1:0];
    h_ok      = ({1'b0, q_op.handle} < (HANDLE_W + 1)'(MAX_HANDLES)) && entry_valid[hidx];
    have_fifo = (fifo_fill != '0);
    have_new  = (next_unused < FILL_W'(MAX_HANDLES));
    nh        = have_fifo ? free_fifo[fifo_head] : next_unused[HIDX_W-1:0];

    cur    = entry_cursor[hidx];
    efile  = entry_file[hidx];
    size   = file_size[efile];
    at_end = (cur >= size);
    avail  = size - cur;
    grant  = at_end ? '0 : ((q_op.count < avail) ? q_op.count : avail);

    open_ok   = 1'b0;
    close_ok  = 1'b0;
    read_ok   = 1'b0;
    res_status = ST_OK;
    case (q_op.kind)
      OP_OPEN: begin
        if (have_fifo || have_new) begin
          open_ok = 1'b1;
        end else begin
          res_status = ST_NO_FREE;
        end
      end
      OP_CLOSE: begin
        if (h_ok) begin
          close_ok = 1'b1;
        end else begin
          res_status = ST_BAD_HANDLE;
        end
      end
      OP_READ: begin
        if (!h_ok) begin
          res_status = ST_BAD_HANDLE;
        end else if ((entry_mode[hidx] & MODE_READ) == '0) begin
          res_status = ST_NOT_READABLE;
        end else begin
          read_ok = 1'b1;
        end
      end
      default: res_status = q_op.reject;
    endcase
    push_free = close_ok && (fifo_fill < FILL_W'(MAX_HANDLES));
  end

  // Table payload, written only by the operation being retired.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (open_ok) begin
        entry_mode[nh]   <= q_op.mode;
        entry_file[nh]   <= q_op.file_index;
        entry_cursor[nh] <= '0;
      end
      if (read_ok) begin
        entry_cursor[hidx] <= cur + grant;
      end
      if (push_free) begin
        free_fifo[fifo_tail] <= hidx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      fifo_head   <= '0;
      fifo_tail   <= '0;
      fifo_fill   <= '0;
      next_unused <= '0;
      rsp.valid   <= 1'b0;
    end else begin
      if (q_pop) begin
        rsp.valid <= 1'b1;
        if (open_ok) begin
          entry_valid[nh] <= 1'b1;
          if (have_fifo) begin
            fifo_head <= (fifo_head == HIDX_W'(MAX_HANDLES - 1)) ? '0 : fifo_head + 1'b1;
          end else begin
            next_unused <= next_unused + 1'b1;
          end
        end
        if (close_ok) begin
          entry_valid[hidx] <= 1'b0;
        end
        case ({open_ok && have_fifo, push_free})
          2'b10:   fifo_fill <= fifo_fill - 1'b1;
          2'b01:   fifo_fill <= fifo_fill + 1'b1;
          default: fifo_fill <= fifo_fill;
        endcase
        if (push_free) begin
          fifo_tail <= (fifo_tail == HIDX_W'(MAX_HANDLES - 1)) ? '0 : fifo_tail + 1'b1;
        end
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rsp.status        <= res_status;
      rsp.handle_out    <= open_ok ? HANDLE_W'(nh) : '0;
      rsp.bytes_granted <= read_ok ? grant : '0;
      rsp.data_offset   <= read_ok ? cur : '0;
      rsp.file_out      <= read_ok ? efile : '0;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_fill <= FILL_W'(MAX_HANDLES))
    else $error("free list fill count above table depth");

  a_open_marks: assert property (@(posedge clk) disable iff (rst)
    q_pop && open_ok |=> entry_valid[$past(nh)])
    else $error("granted handle not marked valid");

  a_grant_bound: assert property (@(posedge clk) disable iff (rst)
    q_pop && read_ok && !at_end |->
      ({1'b0, cur} + {1'b0, grant}) <= {1'b0, size})
    else $error("read grant runs past end of file");

  a_unused_bound: assert property (@(posedge clk) disable iff (rst)
    next_unused <= FILL_W'(MAX_HANDLES))
    else $error("unused handle counter above table depth");
`endif

endmodule

>>> hdl/file_handle_table.sv
// Top level of the handle table block: register file, front end, queue and engine.
//
// Channels: req carries one command per beat (open, close or read), rsp
// returns exactly one result beat per command in command order, and cfg
// writes the file count and the four file size registers. All three use a
// valid/ready handshake; a beat moves on a rising edge with both high.
// The cfg channel is always ready and should only be written while no
// command is outstanding.
//
// Flow: an accepted command is written into a queue slot, then its result
// goes to the result register if that register is free. The front end
// classifies commands into a two-entry queue; while rsp is not stalled the
// engine retires one operation per cycle, reading and updating the handle
// table and free-handle FIFO in that same cycle, so sustained throughput is
// one command per clock.
// Backpressure: when rsp is stalled the result register holds its beat, the
// engine stops retiring and the queue fills; req.ready drops once the queue
// is full. Reset (rst, synchronous) empties the queue, clears every handle's
// valid bit, the free list and the register file; table payload stays as is.
module file_handle_table import fht_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  fht_req_if.sink   req,
  fht_rsp_if.source rsp,
  fht_cfg_if.sink   cfg
);

  logic [PRESENT_W-1:0] files_present;
  size_vec_t            file_size;

  logic q_ready;
  logic q_push;
  op_t  q_in;
  logic q_valid;
  logic q_pop;
  op_t  q_out;

  // Register writes are taken in any cycle.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      files_present <= '0;
      file_size     <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_FILES_PRESENT: files_present <= cfg.data[PRESENT_W-1:0];
        CFG_SIZE_0:        file_size[0]  <= cfg.data[SIZE_W-1:0];
        CFG_SIZE_1:        file_size[1]  <= cfg.data[SIZE_W-1:0];
        CFG_SIZE_2:        file_size[2]  <= cfg.data[SIZE_W-1:0];
        CFG_SIZE_3:        file_size[3]  <= cfg.data[SIZE_W-1:0];
        default:           files_present <= files_present;
      endcase
    end
  end

  // The front end rejects bad modes, missing files and unknown commands early;
  // everything that needs the handle table is decided in the engine.
  fht_front u_front (
    .req           (req),
    .files_present (files_present),
    .q_ready       (q_ready),
    .q_push        (q_push),
    .q_op          (q_in)
  );

  fht_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_op    (q_in),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_op     (q_out)
  );

  fht_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_op      (q_out),
    .q_pop     (q_pop),
    .file_size (file_size),
    .rsp       (rsp)
  );

endmodule
